// ----- hw/rtl/bpa_pkg.sv -----
`default_nettype none

package bpa_pkg;

	localparam int MAX_PAGES  = 4096;
	localparam int WORD_BITS  = 64;
	localparam int WORDS      = MAX_PAGES / WORD_BITS;
	localparam int WADDR_W    = $clog2(WORDS);
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int PIDX_W     = $clog2(MAX_PAGES);
	localparam int ADDR_W     = 48;
	localparam int COUNT_W    = 13;
	localparam int PAGE_SHIFT = 12;
	localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;
	localparam int GRP_BITS   = 8;
	localparam int GRPS       = WORD_BITS / GRP_BITS;
	localparam int GRP_W      = $clog2(GRP_BITS);
	localparam int GSEL_W     = $clog2(GRPS);

	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [COUNT_W-1:0]   count_t;
	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WADDR_W-1:0]   waddr_t;
	typedef logic [BIT_W-1:0]     bit_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_OUTSIDE = 2'd2
	} status_t;

	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	typedef enum logic {
		CFG_POOL_BASE  = 1'b0,
		CFG_POOL_PAGES = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ALLOC_WR,
		S_FREE_CHK,
		S_FREE_WR,
		S_RESP
	} state_t;

	// lowest set bit, found per byte group then within the group
	function automatic bit_t lowest_set(input word_t v);
		logic [GRPS-1:0]     any;
		logic [GSEL_W-1:0]   gsel;
		logic [GRP_BITS-1:0] grp;
		logic [GRP_W-1:0]    lo;
		int                  g;
		int                  b;
		for (g = 0; g < GRPS; g++) begin
			any[g] = |v[g*GRP_BITS +: GRP_BITS];
		end
		gsel = '0;
		for (g = GRPS - 1; g >= 0; g--) begin
			if (any[g]) begin
				gsel = GSEL_W'(g);
			end
		end
		grp = v[gsel*GRP_BITS +: GRP_BITS];
		lo = '0;
		for (b = GRP_BITS - 1; b >= 0; b--) begin
			if (grp[b]) begin
				lo = GRP_W'(b);
			end
		end
		return {gsel, lo};
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bpa_ifs.sv -----
`default_nettype none

interface bpa_req_if;
	import bpa_pkg::*;
	logic  valid;
	logic  ready;
	logic  mode;
	addr_t release_address;
	modport source (output valid, output mode, output release_address, input ready);
	modport sink (input valid, input mode, input release_address, output ready);
endinterface

interface bpa_rsp_if;
	import bpa_pkg::*;
	logic    valid;
	logic    ready;
	addr_t   granted_address;
	status_t status;
	count_t  pages_in_use;
	modport source (output valid, output granted_address, output status,
		output pages_in_use, input ready);
	modport sink (input valid, input granted_address, input status,
		input pages_in_use, output ready);
endinterface

interface bpa_cfg_if;
	import bpa_pkg::*;
	logic     valid;
	logic     ready;
	cfg_reg_t index;
	addr_t    data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bitmap_page_allocator_top.sv -----
`default_nettype none

// First-fit page frame allocator over a 4096-bit usage bitmap held as 64 words of
// 64 bits in a single-port-read memory. An allocate beat scans the words one per
// cycle through one shared find-lowest-clear unit; its steps are accept, scan,
// write-back and response, with no write-back when the pool is full and no scan
// for an empty pool. A free beat steps through offset, read, clear and response,
// skipping the clear when the address lies outside the pool. One request is in
// flight at a time and the request side is not ready meanwhile; a finished result sits
// in an output register so the next request may start before it is taken. Each bitmap
// word has a valid flag cleared by reset, so the bitmap reads as all free at once.
// Configuration writes are always accepted and should only be issued while idle.
module bitmap_page_allocator_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bpa_req_if.sink    req,
	bpa_rsp_if.source  rsp,
	bpa_cfg_if.sink    cfg
);
	import bpa_pkg::*;

	state_t           state_q;
	state_t           state_d;
	addr_t            pool_base_q;
	count_t           pool_pages_q;
	count_t           used_count_q;
	logic [WORDS-1:0] row_valid_q;
	logic             out_valid_q;
	addr_t            out_addr_q;
	status_t          out_status_q;
	count_t           out_count_q;

	word_t            mem [WORDS];
	word_t            rdata_q;
	logic             rrow_q;
	waddr_t           raddr;
	logic             mem_we;
	waddr_t           waddr;
	word_t            wdata;

	waddr_t                word_q;
	bit_t                  bit_q;
	word_t                 new_word_q;
	logic [PAGE_NUM_W-1:0] page_q;
	addr_t                 res_addr_q;
	status_t               res_status_q;

	logic   req_ready;
	count_t limit;
	count_t limit_m1;
	waddr_t last_word;
	bit_t   last_bit;
	word_t  rd_word;
	word_t  scan_mask;
	word_t  avail;
	logic   found;
	bit_t   hit_bit;
	bit_t   free_bit;
	waddr_t free_word;
	logic   free_set;
	logic   outside;
	logic   out_free;
	addr_t  offset;

	assign limit     = (pool_pages_q > COUNT_W'(MAX_PAGES)) ? COUNT_W'(MAX_PAGES) : pool_pages_q;
	assign limit_m1  = limit - COUNT_W'(1);
	assign last_word = limit_m1[PIDX_W-1:BIT_W];
	assign last_bit  = limit_m1[BIT_W-1:0];
	assign rd_word   = rrow_q ? rdata_q : '0;
	assign scan_mask = (word_q == last_word) ?
		({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - last_bit)) : '1;
	assign avail     = ~rd_word & scan_mask;
	assign found     = |avail;
	assign hit_bit   = lowest_set(avail);
	assign free_bit  = page_q[BIT_W-1:0];
	assign free_word = page_q[PIDX_W-1:BIT_W];
	assign free_set  = rd_word[free_bit];
	assign outside   = page_q >= PAGE_NUM_W'(limit);
	assign out_free  = !out_valid_q || rsp.ready;
	assign offset    = req.release_address - pool_base_q;

	assign req.ready           = req_ready;
	assign cfg.ready           = 1'b1;
	assign rsp.valid           = out_valid_q;
	assign rsp.granted_address = out_addr_q;
	assign rsp.status          = out_status_q;
	assign rsp.pages_in_use    = out_count_q;

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		raddr     = WADDR_W'(word_q + WADDR_W'(1));
		mem_we    = 1'b0;
		waddr     = word_q;
		wdata     = new_word_q;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				raddr     = '0;
				if (req.valid) begin
					if (req.mode == MODE_FREE) begin
						state_d = S_FREE_CHK;
					end else if (limit == '0) begin
						state_d = S_RESP;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (found) begin
					state_d = S_ALLOC_WR;
				end else if (word_q == last_word) begin
					state_d = S_RESP;
				end
			end
			S_ALLOC_WR: begin
				mem_we  = 1'b1;
				state_d = S_RESP;
			end
			S_FREE_CHK: begin
				raddr   = free_word;
				state_d = outside ? S_RESP : S_FREE_WR;
			end
			S_FREE_WR: begin
				mem_we  = free_set;
				waddr   = free_word;
				wdata   = rd_word & ~(word_t'(1) << free_bit);
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pool_base_q  <= '0;
			pool_pages_q <= '0;
			used_count_q <= '0;
			row_valid_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_POOL_BASE:  pool_base_q  <= cfg.data;
					CFG_POOL_PAGES: pool_pages_q <= cfg.data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (state_q == S_ALLOC_WR) begin
				row_valid_q[word_q] <= 1'b1;
				used_count_q        <= used_count_q + COUNT_W'(1);
			end
			if (state_q == S_FREE_WR && free_set && used_count_q != '0) begin
				used_count_q <= used_count_q - COUNT_W'(1);
			end
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// bitmap memory, registered read
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		rrow_q  <= row_valid_q[raddr];
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				word_q       <= '0;
				page_q       <= offset[ADDR_W-1:PAGE_SHIFT];
				res_addr_q   <= '0;
				res_status_q <= (req.mode == MODE_ALLOC && limit == '0) ? ST_FULL : ST_DONE;
			end
			S_SCAN: begin
				if (found) begin
					bit_q      <= hit_bit;
					new_word_q <= rd_word | (word_t'(1) << hit_bit);
				end else if (word_q == last_word) begin
					res_status_q <= ST_FULL;
				end else begin
					word_q <= WADDR_W'(word_q + WADDR_W'(1));
				end
			end
			S_ALLOC_WR: begin
				res_addr_q   <= pool_base_q + (ADDR_W'({word_q, bit_q}) << PAGE_SHIFT);
				res_status_q <= ST_DONE;
			end
			S_FREE_CHK: begin
				res_status_q <= outside ? ST_OUTSIDE : ST_DONE;
			end
			S_FREE_WR: ;
			S_RESP: begin
				if (out_free) begin
					out_addr_q   <= res_addr_q;
					out_status_q <= res_status_q;
					out_count_q  <= used_count_q;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire
